// ===== sv/isqrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the integer square root block.
package isqrt_pkg;

    // Default width of the signed input value.
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the root field on the result port.
    localparam int ROOT_OUT_WIDTH = 16;

    // Largest value that the root field can show.
    localparam logic [ROOT_OUT_WIDTH-1:0] ROOT_MAX = '1;

    // Control that travels with each request along the row of cells.
    typedef struct packed {
        logic valid;  // a request occupies this stage
        logic neg;    // the request carried a negative value
    } t_ctl;

endpackage

// ===== sv/isqrt_cell.sv =====
`timescale 1ns / 1ps
// One stage of the digit-by-digit square root: settles one root bit per request.
module isqrt_cell #(
    parameter int ROOT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isqrt_pkg::t_ctl        i_ctl,
    input  logic [2*ROOT_BITS-1:0] i_rad,
    input  logic [ROOT_BITS+1:0]   i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    output isqrt_pkg::t_ctl        o_ctl,
    output logic [2*ROOT_BITS-1:0] o_rad,
    output logic [ROOT_BITS+1:0]   o_rem,
    output logic [ROOT_BITS-1:0]   o_root
);

    localparam int WIDE = ROOT_BITS + 4;

    isqrt_pkg::t_ctl        r_ctl;
    logic [2*ROOT_BITS-1:0] r_rad;
    logic [ROOT_BITS+1:0]   r_rem;
    logic [ROOT_BITS-1:0]   r_root;

    logic [2*ROOT_BITS-1:0] n_rad;
    logic [ROOT_BITS+1:0]   n_rem;
    logic [ROOT_BITS-1:0]   n_root;

    logic [WIDE-1:0] wide_rem;
    logic [WIDE-1:0] trial;
    logic [WIDE-1:0] diff;
    logic            fits;

    // Bring down the next two radicand bits and try to append a one to the root.
    always_comb begin
        wide_rem = {i_rem, i_rad[2*ROOT_BITS-1 -: 2]};
        trial    = {2'b00, i_root, 2'b01};
        fits     = (wide_rem >= trial);
        diff     = wide_rem - trial;
        n_rem    = fits ? diff[ROOT_BITS+1:0] : wide_rem[ROOT_BITS+1:0];
        n_root   = {i_root[ROOT_BITS-2:0], fits};
        n_rad    = {i_rad[2*ROOT_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== sv/integer_square_root.sv =====
`timescale 1ns / 1ps
// Top level of the integer square root block: a row of root-bit cells.
//
// Usage: the caller presents a signed value on i_value and raises start. A
// request is taken at every rising clock edge at which start is high and busy
// is low. The block is a row of VALUE_WIDTH/2 identical cells, each of which
// settles one bit of the root by a trial subtraction and hands the partial
// root, remainder and remaining radicand bits to its neighbor. Because every
// cell works on a different request, busy stays low and a new request may be
// given in every cycle.
//
// A request passes through the registers of each cell in turn; o_strobe comes
// straight from the last cell's control register and marks the result on
// o_root and o_negative_error for one cycle. Results leave in request
// order. The receiver cannot stall the block; it takes each result while
// o_strobe is high.
//
// A negative value gives root zero with o_negative_error set. Roots that need
// more than sixteen bits, possible only for widths above 32, saturate at the
// largest sixteen-bit value. Reset empties the row of cells; requests that
// were in flight are dropped and no strobe follows them.
module integer_square_root #(
    parameter int VALUE_WIDTH = isqrt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [VALUE_WIDTH-1:0]        i_value,
    output logic                                 o_strobe,
    output logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0] o_root,
    output logic                                 o_negative_error
);

    // The magnitude of a non-negative value has VALUE_WIDTH-1 bits, so its
    // root has this many bits, one cell per bit.
    localparam int ROOT_BITS = VALUE_WIDTH / 2;
    localparam int OUT_W     = isqrt_pkg::ROOT_OUT_WIDTH;
    localparam int EXT_W     = (ROOT_BITS > OUT_W) ? ROOT_BITS : OUT_W;

    isqrt_pkg::t_ctl        ctl  [ROOT_BITS+1];
    logic [2*ROOT_BITS-1:0] rad  [ROOT_BITS+1];
    logic [ROOT_BITS+1:0]   rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]   root [ROOT_BITS+1];

    logic [EXT_W-1:0] root_ext;
    logic             root_sat;

    // Every cell holds its own request, so the entry is always open.
    assign busy = 1'b0;

    // The first cell starts from an empty remainder and root; the sign bit is
    // split off and only the magnitude bits enter the radicand.
    assign ctl[0]  = '{valid: start, neg: i_value[VALUE_WIDTH-1]};
    assign rad[0]  = (2*ROOT_BITS)'(unsigned'(i_value[VALUE_WIDTH-2:0]));
    assign rem[0]  = '0;
    assign root[0] = '0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
        isqrt_cell #(
            .ROOT_BITS(ROOT_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl[k]),
            .i_rad  (rad[k]),
            .i_rem  (rem[k]),
            .i_root (root[k]),
            .o_ctl  (ctl[k+1]),
            .o_rad  (rad[k+1]),
            .o_rem  (rem[k+1]),
            .o_root (root[k+1])
        );
    end

    // The last cell's registers are the result; only the saturation and the
    // error override are formed after them.
    always_comb begin
        root_ext = EXT_W'(root[ROOT_BITS]);
        root_sat = (root_ext > EXT_W'(isqrt_pkg::ROOT_MAX));
        if (ctl[ROOT_BITS].neg) begin
            o_root = '0;
        end else if (root_sat) begin
            o_root = isqrt_pkg::ROOT_MAX;
        end else begin
            o_root = root_ext[OUT_W-1:0];
        end
    end

    assign o_strobe         = ctl[ROOT_BITS].valid;
    assign o_negative_error = ctl[ROOT_BITS].neg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the integer square root block with a result scoreboard.

// One expected result of the block.
typedef struct {
    logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0] root;
    logic                                 negative;
} t_root_result;

// Computes the expected root for every request and holds it until the block answers.
class root_scoreboard;
    t_root_result pending_roots[$];
    int unsigned  failures;

    function new();
        failures = 0;
    endfunction

    // Floor of the square root, one root bit at a time from the top.
    static function logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0] floor_sqrt(logic [31:0] magnitude);
        logic [63:0]                          trial;
        logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0] partial;
        partial = '0;
        for (int b = isqrt_pkg::ROOT_OUT_WIDTH - 1; b >= 0; b--) begin
            trial = {48'd0, partial} | (64'd1 << b);
            if (trial * trial <= {32'd0, magnitude}) begin
                partial = trial[isqrt_pkg::ROOT_OUT_WIDTH-1:0];
            end
        end
        return partial;
    endfunction

    function void note_request(logic [31:0] value);
        t_root_result predicted;
        if (value[31]) begin
            predicted.root     = '0;
            predicted.negative = 1'b1;
        end else begin
            predicted.root     = floor_sqrt(value);
            predicted.negative = 1'b0;
        end
        pending_roots.push_back(predicted);
    endfunction

    function void check_result(logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0] root, logic negative);
        t_root_result oldest;
        if (pending_roots.size() == 0) begin
            $error("unexpected result: root %0d negative_error %0b", root, negative);
            failures++;
            return;
        end
        oldest = pending_roots.pop_front();
        if (root !== oldest.root) begin
            $error("root mismatch: expected %0d, actual %0d", oldest.root, root);
            failures++;
        end
        if (negative !== oldest.negative) begin
            $error("negative_error mismatch: expected %0b, actual %0b",
                   oldest.negative, negative);
            failures++;
        end
    endfunction

    function int unsigned outstanding();
        return pending_roots.size();
    endfunction
endclass

module testbench;

    // Depth of the block's row of cells, used to size the final wait.
    localparam int LATENCY      = isqrt_pkg::VALUE_WIDTH_DEF / 2;
    localparam int RANDOM_ITEMS = 1850;
    // Worst case is roughly every request followed by the longest idle gap
    // plus the pipeline; this limit is several times that.
    localparam int CYCLE_LIMIT  = 500000;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     start = 1'b0;
    logic signed [isqrt_pkg::VALUE_WIDTH_DEF-1:0] i_value = '0;
    logic                                     busy;
    logic                                     o_strobe;
    logic [isqrt_pkg::ROOT_OUT_WIDTH-1:0]     o_root;
    logic                                     o_negative_error;

    root_scoreboard board;
    int unsigned    cycle_count = 0;

    integer_square_root #(
        .VALUE_WIDTH(isqrt_pkg::VALUE_WIDTH_DEF)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_root          (o_root),
        .o_negative_error(o_negative_error)
    );

    // Free-running clock with a 4 ns period.
    always #2 i_clk = ~i_clk;

    // Watchdog: a hung block or a lost result ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results are sampled on the falling edge, half a cycle away from the edge
    // at which the block updates them, so nothing here depends on the order of
    // events inside one time step. The receiver cannot stall the block, so each
    // strobed result is checked in the cycle in which it appears.
    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_result(o_root, o_negative_error);
        end
    end

    // Presents one request and returns at the edge that takes it. The task is
    // entered just after a rising edge. Busy can only change at a rising edge,
    // so its value at the falling edge is the one that decides the next edge.
    task automatic issue_request(input logic [31:0] value);
        start   <= 1'b1;
        i_value <= value;
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        board.note_request(value);
    endtask

    // Drops start for a number of cycles; a zero gap keeps start high so that
    // the next request follows back to back.
    task automatic hold_off(input int unsigned cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int unsigned gap_length(input bit idling);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idling || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Random values weighted toward the places where a root search goes wrong:
    // exact squares and their neighbors, small values, values of every
    // magnitude, and negative values with random lower bits.
    function automatic logic [31:0] random_value();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4: begin
                k = $urandom_range(0, 46340);
                return k * k;
            end
            5: begin
                k = $urandom_range(1, 46340);
                return k * k - 1;
            end
            6: begin
                k = $urandom_range(0, 46339);
                return k * k + $urandom_range(1, 2 * k);
            end
            7: return $urandom_range(0, 1023);
            8: return ($urandom & 32'h7FFF_FFFF) >> $urandom_range(1, 30);
            default: return $urandom | 32'h8000_0000;
        endcase
    endfunction

    initial begin
        // Corner values: zero, the smallest roots, squares and the values just
        // below them, the largest positive value (whose square root falls just
        // short of the next integer), the largest exact square that fits, and
        // negative values including the most negative one.
        logic [31:0] corners[] = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16,
            32'd17, 32'd255, 32'd256, 32'd65535, 32'd65536,
            32'd2147395600, 32'd2147395599, 32'd2147395601,
            32'h7FFF_FFFF, 32'h4000_0000, 32'h3FFF_FFFF,
            32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
        };
        bit idling;

        board = new();

        // Synchronous reset held at the start of the run, and never again.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, alternating back-to-back and spaced requests.
        foreach (corners[n]) begin
            issue_request(corners[n]);
            hold_off(n % 2);
        end

        // Random part. Every third block of requests runs with no idling so
        // that the pipeline is full for long stretches.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling = ((n / 150) % 3) != 0;
            issue_request(random_value());
            if (n == RANDOM_ITEMS / 2) begin
                // Let the pipeline drain completely before sending more.
                start <= 1'b0;
                while (board.outstanding() != 0) begin
                    @(posedge i_clk);
                end
            end else begin
                hold_off(gap_length(idling));
            end
        end
        start <= 1'b0;

        // Wait for every outstanding result, then a while longer to catch any
        // stray strobe.
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * LATENCY + 8) @(posedge i_clk);

        if (board.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
